/* rtl/core/wfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_pkg
// Shared constants and types of the worst-fit allocator.
// ----------------------------------------------------------------------------
package wfa_pkg;

  localparam int MaxRequests = 1024;
  localparam int MaxSegments = 1025;
  localparam int UnitW       = 31;

  localparam logic [UnitW-1:0] MemSizeReset = 31'd1024;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctl_t;

endpackage

/* rtl/core/worst_fit_allocator_with_coalescing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_allocator_with_coalescing
// Worst-fit allocator over a linked segment table with free-neighbor merging.
// ----------------------------------------------------------------------------
// Requests enter on in_valid_i/in_stall_o: op_i 0 allocates alloc_size_i
// units, op_i 1 frees the block of an earlier request_number_i. Only
// allocations give a result on out_valid_o/out_stall_i (status_o,
// address_o). The block takes one request at a time and holds in_stall_o
// high until it is done, and while a memory_size write is pending.
// An allocation walks the segment table one entry per cycle through the
// compare unit, then updates the table and hands its result to the output
// register. A request that hits the request limit goes straight to the output
// register. A free reads its owner entry, then the segment and its neighbours.
// The result sits in an output register; while the receiver stalls, the
// block still accepts new requests, and an allocation waits at its end
// until the register is free.
// After reset, or a write of memory_size on cfg_valid_i/cfg_ready_o, the
// S_INIT state rebuilds the table as a single free segment; cfg_ready_o is
// high only while the block is idle.
// ----------------------------------------------------------------------------
module worst_fit_allocator_with_coalescing #(
  parameter int MAX_REQUESTS = wfa_pkg::MaxRequests,
  parameter int MAX_SEGMENTS = wfa_pkg::MaxSegments
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [30:0] alloc_size_i,
  input  logic [11:0] request_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [30:0] address_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] memory_size_i
);

  localparam int SW     = $clog2(MAX_SEGMENTS + 1);
  localparam int RW     = $clog2(MAX_REQUESTS + 1);
  localparam int RecW   = 64 + 2 * SW;
  localparam int ONext  = 0;
  localparam int OPrev  = SW;
  localparam int OAlive = 2 * SW;
  localparam int OFree  = 2 * SW + 1;
  localparam int OLast  = 2 * SW + 2;
  localparam int OStart = 2 * SW + 33;

  typedef enum logic [16:0] {
    S_INIT    = 17'b00000000000000001,
    S_IDLE    = 17'b00000000000000010,
    S_A_SCAN  = 17'b00000000000000100,
    S_A_DRAIN = 17'b00000000000001000,
    S_A_DEC   = 17'b00000000000010000,
    S_A_FRESH = 17'b00000000000100000,
    S_A_NEXT  = 17'b00000000001000000,
    S_A_BEST  = 17'b00000000010000000,
    S_A_OUT   = 17'b00000000100000000,
    S_F_RDO   = 17'b00000001000000000,
    S_F_OWN   = 17'b00000010000000000,
    S_F_CUR   = 17'b00000100000000000,
    S_F_PREV  = 17'b00001000000000000,
    S_F_N     = 17'b00010000000000000,
    S_F_NCHK  = 17'b00100000000000000,
    S_F_MFIX  = 17'b01000000000000000,
    S_F_FIN   = 17'b10000000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [30:0]     msize_q, msize_d;
  logic [RW-1:0]   cnt_q, cnt_d;
  logic [SW-1:0]   segcnt_q, segcnt_d;
  logic [SW-1:0]   s_q, s_d;
  logic            dv_q, dv_d;
  logic [SW-1:0]   sidx_q;
  logic [RW-1:0]   req_q, req_d;
  logic [30:0]     size_q, size_d;
  logic [11:0]     t_q, t_d;
  logic [SW-1:0]   cidx_q, cidx_d;
  logic [RecW-1:0] crec_q, crec_d;
  logic [SW-1:0]   fresh_q, fresh_d;
  logic [SW-1:0]   m_q, m_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [30:0]     res_addr_q, res_addr_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [30:0]     out_addr_q, out_addr_d;

  logic            seg_we;
  logic [SW-1:0]   seg_waddr, seg_raddr;
  logic [RecW-1:0] seg_wdata, seg_rdata;
  logic            own_we;
  logic [RW-1:0]   own_waddr, own_raddr;
  logic [SW-1:0]   own_wdata, own_rdata;

  wfa_pkg::scan_ctl_t scan_ctl;
  logic               b_found;
  logic [SW-1:0]      b_idx;
  logic [RecW-1:0]    b_rec;
  logic [30:0]        b_len;

  logic            accept;
  logic [RecW-1:0] tmp;
  logic [SW-1:0]   nidx;
  logic            t_ok;

  wfa_ram #(.W(RecW), .D(MAX_SEGMENTS + 1), .AW(SW)) u_seg (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  wfa_ram #(.W(SW), .D(MAX_REQUESTS + 1), .AW(RW)) u_own (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  wfa_scan #(.SW(SW), .RecW(RecW)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .idx_i   (sidx_q),
    .rec_i   (seg_rdata),
    .found_o (b_found),
    .idx_o   (b_idx),
    .rec_o   (b_rec),
    .len_o   (b_len)
  );

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign nidx        = crec_q[ONext +: SW];
  assign t_ok        = (t_q != 12'd0) && (32'(t_q) <= 32'(cnt_q));

  always_comb begin
    state_d      = state_q;
    msize_d      = msize_q;
    cnt_d        = cnt_q;
    segcnt_d     = segcnt_q;
    s_d          = s_q;
    dv_d         = 1'b0;
    req_d        = req_q;
    size_d       = size_q;
    t_d          = t_q;
    cidx_d       = cidx_q;
    crec_d       = crec_q;
    fresh_d      = fresh_q;
    m_d          = m_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    seg_we       = 1'b0;
    seg_waddr    = '0;
    seg_wdata    = '0;
    seg_raddr    = '0;
    own_we       = 1'b0;
    own_waddr    = '0;
    own_wdata    = '0;
    own_raddr    = '0;
    scan_ctl     = '0;
    tmp          = '0;

    case (state_q)
      S_INIT: begin
        seg_we    = 1'b1;
        seg_waddr = SW'(1);
        seg_wdata = {31'd1, msize_q, 1'b1, 1'b1, {SW{1'b0}}, {SW{1'b0}}};
        cnt_d     = '0;
        segcnt_d  = SW'(1);
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          msize_d = memory_size_i;
          state_d = S_INIT;
        end else if (accept) begin
          size_d = alloc_size_i;
          t_d    = request_number_i;
          if (!op_i) begin
            if (32'(cnt_q) >= 32'(MAX_REQUESTS)) begin
              res_status_d = wfa_pkg::ST_FULL;
              res_addr_d   = '0;
              state_d      = S_A_OUT;
            end else begin
              cnt_d        = cnt_q + RW'(1);
              req_d        = cnt_q + RW'(1);
              s_d          = SW'(1);
              scan_ctl.clr = 1'b1;
              state_d      = S_A_SCAN;
            end
          end else begin
            if (32'(cnt_q) < 32'(MAX_REQUESTS)) begin
              cnt_d     = cnt_q + RW'(1);
              own_we    = 1'b1;
              own_waddr = cnt_q + RW'(1);
            end
            state_d = S_F_RDO;
          end
        end
      end
      S_A_SCAN: begin
        seg_raddr = s_q;
        dv_d      = 1'b1;
        if (s_q == segcnt_q) begin
          state_d = S_A_DRAIN;
        end else begin
          s_d = s_q + SW'(1);
        end
      end
      S_A_DRAIN: begin
        state_d = S_A_DEC;
      end
      S_A_DEC: begin
        res_addr_d = '0;
        if (size_q == 31'd0 || !b_found || b_len < size_q) begin
          res_status_d = wfa_pkg::ST_NOFIT;
          own_we       = 1'b1;
          own_waddr    = req_q;
          state_d      = S_A_OUT;
        end else if (b_len != size_q) begin
          if (32'(segcnt_q) >= 32'(MAX_SEGMENTS)) begin
            res_status_d = wfa_pkg::ST_FULL;
            own_we       = 1'b1;
            own_waddr    = req_q;
            state_d      = S_A_OUT;
          end else begin
            state_d = S_A_FRESH;
          end
        end else begin
          tmp          = b_rec;
          tmp[OFree]   = 1'b0;
          seg_we       = 1'b1;
          seg_waddr    = b_idx;
          seg_wdata    = tmp;
          own_we       = 1'b1;
          own_waddr    = req_q;
          own_wdata    = b_idx;
          res_status_d = wfa_pkg::ST_OK;
          res_addr_d   = b_rec[OStart +: 31];
          state_d      = S_A_OUT;
        end
      end
      S_A_FRESH: begin
        seg_we    = 1'b1;
        seg_waddr = segcnt_q + SW'(1);
        seg_wdata = {b_rec[OStart +: 31] + size_q, b_rec[OLast +: 31], 1'b1, 1'b1,
                     b_idx, b_rec[ONext +: SW]};
        segcnt_d  = segcnt_q + SW'(1);
        fresh_d   = segcnt_q + SW'(1);
        if (b_rec[ONext +: SW] != '0) begin
          seg_raddr = b_rec[ONext +: SW];
          state_d   = S_A_NEXT;
        end else begin
          state_d = S_A_BEST;
        end
      end
      S_A_NEXT: begin
        tmp             = seg_rdata;
        tmp[OPrev +: SW] = fresh_q;
        seg_we          = 1'b1;
        seg_waddr       = b_rec[ONext +: SW];
        seg_wdata       = tmp;
        state_d         = S_A_BEST;
      end
      S_A_BEST: begin
        tmp              = b_rec;
        tmp[OLast +: 31] = b_rec[OStart +: 31] + size_q - 31'd1;
        tmp[ONext +: SW] = fresh_q;
        tmp[OFree]       = 1'b0;
        seg_we           = 1'b1;
        seg_waddr        = b_idx;
        seg_wdata        = tmp;
        own_we           = 1'b1;
        own_waddr        = req_q;
        own_wdata        = b_idx;
        res_status_d     = wfa_pkg::ST_OK;
        res_addr_d       = b_rec[OStart +: 31];
        state_d          = S_A_OUT;
      end
      S_A_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end
      S_F_RDO: begin
        if (t_ok) begin
          own_raddr = RW'(t_q);
          state_d   = S_F_OWN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_F_OWN: begin
        own_we    = 1'b1;
        own_waddr = RW'(t_q);
        if (own_rdata == '0) begin
          state_d = S_IDLE;
        end else begin
          seg_raddr = own_rdata;
          cidx_d    = own_rdata;
          state_d   = S_F_CUR;
        end
      end
      S_F_CUR: begin
        if (!seg_rdata[OAlive] || seg_rdata[OFree]) begin
          state_d = S_IDLE;
        end else begin
          crec_d = seg_rdata;
          if (seg_rdata[OPrev +: SW] != '0) begin
            seg_raddr = seg_rdata[OPrev +: SW];
            state_d   = S_F_PREV;
          end else begin
            state_d = S_F_N;
          end
        end
      end
      S_F_PREV: begin
        if (seg_rdata[OAlive] && seg_rdata[OFree]) begin
          tmp         = crec_q;
          tmp[OAlive] = 1'b0;
          tmp[OFree]  = 1'b1;
          seg_we      = 1'b1;
          seg_waddr   = cidx_q;
          seg_wdata   = tmp;
          crec_d                = seg_rdata;
          crec_d[OLast +: 31]   = crec_q[OLast +: 31];
          crec_d[ONext +: SW]   = crec_q[ONext +: SW];
          cidx_d                = crec_q[OPrev +: SW];
        end
        state_d = S_F_N;
      end
      S_F_N: begin
        if (nidx != '0) begin
          seg_raddr = nidx;
          state_d   = S_F_NCHK;
        end else begin
          state_d = S_F_FIN;
        end
      end
      S_F_NCHK: begin
        tmp       = seg_rdata;
        seg_we    = 1'b1;
        seg_waddr = nidx;
        if (seg_rdata[OAlive] && seg_rdata[OFree]) begin
          tmp[OAlive]         = 1'b0;
          crec_d[OLast +: 31] = seg_rdata[OLast +: 31];
          crec_d[ONext +: SW] = seg_rdata[ONext +: SW];
          if (seg_rdata[ONext +: SW] != '0) begin
            seg_raddr = seg_rdata[ONext +: SW];
            m_d       = seg_rdata[ONext +: SW];
            state_d   = S_F_MFIX;
          end else begin
            state_d = S_F_FIN;
          end
        end else begin
          tmp[OPrev +: SW] = cidx_q;
          state_d          = S_F_FIN;
        end
        seg_wdata = tmp;
      end
      S_F_MFIX: begin
        tmp              = seg_rdata;
        tmp[OPrev +: SW] = cidx_q;
        seg_we           = 1'b1;
        seg_waddr        = m_q;
        seg_wdata        = tmp;
        state_d          = S_F_FIN;
      end
      S_F_FIN: begin
        tmp        = crec_q;
        tmp[OFree] = 1'b1;
        seg_we     = 1'b1;
        seg_waddr  = cidx_q;
        seg_wdata  = tmp;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    scan_ctl.vld = dv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      msize_q     <= wfa_pkg::MemSizeReset;
      cnt_q       <= '0;
      segcnt_q    <= SW'(1);
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      msize_q     <= msize_d;
      cnt_q       <= cnt_d;
      segcnt_q    <= segcnt_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    sidx_q       <= s_q;
    req_q        <= req_d;
    size_q       <= size_d;
    t_q          <= t_d;
    cidx_q       <= cidx_d;
    crec_q       <= crec_d;
    fresh_q      <= fresh_d;
    m_q          <= m_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign address_o   = out_addr_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("block took a request without going busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == wfa_pkg::ST_OK || status_o == wfa_pkg::ST_NOFIT ||
                     status_o == wfa_pkg::ST_FULL))
    else $error("unknown status code");

  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != wfa_pkg::ST_OK |-> address_o == 31'd0)
    else $error("failed allocation with nonzero address");
`endif

endmodule

/* rtl/core/wfa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module wfa_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/wfa_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_scan
// Running search for the longest free segment, lowest start on a tie.
// ----------------------------------------------------------------------------
module wfa_scan #(
  parameter int SW   = 11,
  parameter int RecW = 86
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wfa_pkg::scan_ctl_t ctl_i,
  input  logic [SW-1:0]      idx_i,
  input  logic [RecW-1:0]    rec_i,
  output logic               found_o,
  output logic [SW-1:0]      idx_o,
  output logic [RecW-1:0]    rec_o,
  output logic [30:0]        len_o
);

  localparam int OAlive = 2 * SW;
  localparam int OFree  = 2 * SW + 1;
  localparam int OLast  = 2 * SW + 2;
  localparam int OStart = 2 * SW + 33;

  logic            found_q;
  logic [SW-1:0]   idx_q;
  logic [RecW-1:0] rec_q;
  logic [30:0]     len_q;
  logic [30:0]     len;
  logic            take;

  assign len  = rec_i[OLast +: 31] - rec_i[OStart +: 31] + 31'd1;
  assign take = ctl_i.vld && rec_i[OAlive] && rec_i[OFree] &&
                (!found_q || len > len_q ||
                 (len == len_q && rec_i[OStart +: 31] < rec_q[OStart +: 31]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clr) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q <= idx_i;
      rec_q <= rec_i;
      len_q <= len;
    end
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign rec_o   = rec_q;
  assign len_o   = len_q;

endmodule
